// ===== rtl/core/svf_pkg.sv =====
// ----------------------------------------------------------------------------
// svf_pkg
// Shared constants, microcode types and helper functions for the
// state-variable filter.
// ----------------------------------------------------------------------------
package svf_pkg;

  // Data widths
  localparam int SAMPLE_BITS = 16;
  localparam int STATE_BITS  = 24;
  localparam int MAX_PASSES  = 4;
  localparam int COEF_FRAC   = 14;
  localparam int FREQ_BITS   = 15;
  localparam int DAMP_BITS   = 16;
  localparam int MODE_BITS   = 2;
  localparam int PASSES_BITS = 3;
  localparam int COEF_BITS   = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 2;

  // Signed coefficient (zero extended) times signed state
  localparam int PROD_BITS = COEF_BITS + 1 + STATE_BITS;
  localparam int RND_BITS  = PROD_BITS - COEF_FRAC;
  localparam int SUM_BITS  = RND_BITS + 2;
  localparam int PASS_W    = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FREQ   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_DAMP   = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_PASSES = CFG_ADDR_W'(3);

  // Output modes
  localparam logic [MODE_BITS-1:0] MODE_LOW   = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_HIGH  = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_BAND  = MODE_BITS'(2);
  localparam logic [MODE_BITS-1:0] MODE_NOTCH = MODE_BITS'(3);

  // Reset values
  localparam logic [FREQ_BITS-1:0]   FREQ_RST   = FREQ_BITS'(1167);
  localparam logic [DAMP_BITS-1:0]   DAMP_RST   = DAMP_BITS'(16384);
  localparam logic [PASSES_BITS-1:0] PASSES_RST = PASSES_BITS'(2);

  // Program steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_MUL_FB = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOW    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_DB = 3'd2;
  localparam logic [STEP_W-1:0] STEP_HIGH   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_FH = 3'd4;
  localparam logic [STEP_W-1:0] STEP_BAND   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_LOW,
    OP_HIGH,
    OP_BAND,
    OP_EMIT
  } op_e;

  typedef enum logic {
    COEF_FREQ,
    COEF_DAMP
  } coef_sel_e;

  typedef enum logic {
    OPND_BAND,
    OPND_HIGH
  } opnd_sel_e;

  typedef struct packed {
    op_e       op;
    coef_sel_e coef;
    opnd_sel_e opnd;
    logic      loop;
  } uword_t;

  // Control store: one word per step of a filter pass
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_EMIT, coef: COEF_FREQ, opnd: OPND_BAND, loop: 1'b0};
    unique case (step)
      STEP_MUL_FB: w = '{op: OP_MUL,  coef: COEF_FREQ, opnd: OPND_BAND, loop: 1'b0};
      STEP_LOW:    w = '{op: OP_LOW,  coef: COEF_FREQ, opnd: OPND_BAND, loop: 1'b0};
      STEP_MUL_DB: w = '{op: OP_MUL,  coef: COEF_DAMP, opnd: OPND_BAND, loop: 1'b0};
      STEP_HIGH:   w = '{op: OP_HIGH, coef: COEF_FREQ, opnd: OPND_BAND, loop: 1'b0};
      STEP_MUL_FH: w = '{op: OP_MUL,  coef: COEF_FREQ, opnd: OPND_HIGH, loop: 1'b0};
      STEP_BAND:   w = '{op: OP_BAND, coef: COEF_FREQ, opnd: OPND_BAND, loop: 1'b1};
      default:     w = '{op: OP_EMIT, coef: COEF_FREQ, opnd: OPND_BAND, loop: 1'b0};
    endcase
    return w;
  endfunction

  // Clamp a wide sum to the signed state range
  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'(signed'({1'b0, {(STATE_BITS-1){1'b1}}}));
    lo = SUM_BITS'(signed'({1'b1, {(STATE_BITS-1){1'b0}}}));
    if (v > hi) begin
      return hi[STATE_BITS-1:0];
    end else if (v < lo) begin
      return lo[STATE_BITS-1:0];
    end
    return v[STATE_BITS-1:0];
  endfunction

  // Clamp a state value to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [STATE_BITS-1:0] v
  );
    logic signed [STATE_BITS-1:0] hi;
    logic signed [STATE_BITS-1:0] lo;
    hi = STATE_BITS'(signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
    lo = STATE_BITS'(signed'({1'b1, {(SAMPLE_BITS-1){1'b0}}}));
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/state_variable_filter.sv =====
// ----------------------------------------------------------------------------
// state_variable_filter
// Chamberlin state-variable filter with oversampling, run by a small
// microcoded sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel (tdata = sample_in, signed 16 bits)
//   and one filtered sample leaves on the m_axis channel per input
//   transaction (tdata = sample_out, signed 16 bits).
//   The cfg port writes freq_coef, damping, mode and passes; write it only
//   while no sample is in flight.
//   Each pass is six program steps (three multiplies on the shared
//   multiplier, each followed by a saturating add), plus one emit step;
//   passes is clamped to 1..4. The next sample is accepted the cycle
//   after the emit.
//   If the receiver stalls, the finished result waits in the output
//   register and a new sample may still be accepted; its emit step holds
//   until the waiting result has been taken.
//   Reset clears both filter states, the output valid and the sequencer,
//   and loads the register defaults (500 Hz at 44.1 kHz, Q of one,
//   lowpass, two passes).
// ----------------------------------------------------------------------------
module state_variable_filter
  import svf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] sample_in
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata    // [15:0] sample_out
);

  // Configuration registers
  logic [FREQ_BITS-1:0]   freq_q;
  logic [DAMP_BITS-1:0]   damp_q;
  logic [MODE_BITS-1:0]   mode_q;
  logic [PASSES_BITS-1:0] passes_q;

  // Sequencer
  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic [PASS_W-1:0] pass_last_q;
  logic [PASS_W-1:0] pass_last_d;
  uword_t            uw;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [STATE_BITS-1:0]  band_dly_q;
  logic signed [STATE_BITS-1:0]  low_dly_q;
  logic signed [STATE_BITS-1:0]  low_q;
  logic signed [STATE_BITS-1:0]  high_q;
  logic signed [STATE_BITS-1:0]  band_q;
  logic signed [STATE_BITS-1:0]  notch_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  logic                          in_fire;
  logic                          emit_ok;
  logic signed [COEF_BITS:0]     coef;
  logic signed [STATE_BITS-1:0]  opnd;
  logic signed [PROD_BITS-1:0]   prod_rnd;
  logic signed [RND_BITS-1:0]    rnd;
  logic signed [SUM_BITS-1:0]    low_sum;
  logic signed [SUM_BITS-1:0]    high_sum;
  logic signed [SUM_BITS-1:0]    band_sum;
  logic signed [SUM_BITS-1:0]    notch_sum;
  logic signed [STATE_BITS-1:0]  sel;

  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Write configuration registers, masking to width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q   <= FREQ_RST;
      damp_q   <= DAMP_RST;
      mode_q   <= MODE_LOW;
      passes_q <= PASSES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FREQ:   freq_q   <= cfg_wdata_i[FREQ_BITS-1:0];
        REG_DAMP:   damp_q   <= cfg_wdata_i[DAMP_BITS-1:0];
        REG_MODE:   mode_q   <= cfg_wdata_i[MODE_BITS-1:0];
        REG_PASSES: passes_q <= cfg_wdata_i[PASSES_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the pass count to 1..MAX_PASSES, held as the last pass index
  always_comb begin
    if (passes_q == '0) begin
      pass_last_d = '0;
    end else if (32'(passes_q) > MAX_PASSES) begin
      pass_last_d = PASS_W'(MAX_PASSES - 1);
    end else begin
      pass_last_d = PASS_W'(32'(passes_q) - 1);
    end
  end

  // Fetch the control word for the current step
  assign uw = ucode(step_q);

  // Step counter and conditional jump
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    pass_d = pass_q;
    if (!busy_q) begin
      if (in_fire) begin
        busy_d = 1'b1;
        step_d = STEP_MUL_FB;
        pass_d = '0;
      end
    end else begin
      priority if (uw.op == OP_EMIT) begin
        if (emit_ok) begin
          busy_d = 1'b0;
        end
      end else if (uw.loop && (pass_q != pass_last_q)) begin
        step_d = STEP_MUL_FB;
        pass_d = pass_q + PASS_W'(1);
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_MUL_FB;
      pass_q      <= '0;
      pass_last_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      pass_q <= pass_d;
      if (in_fire) begin
        pass_last_q <= pass_last_d;
      end
    end
  end

  // Shared multiplier with rounding offset
  assign coef = (uw.coef == COEF_FREQ) ? (COEF_BITS+1)'({1'b0, freq_q})
                                       : (COEF_BITS+1)'({1'b0, damp_q});
  assign opnd = (uw.opnd == OPND_BAND) ? band_dly_q : high_q;
  assign prod_rnd = PROD_BITS'(coef) * PROD_BITS'(opnd)
                  + PROD_BITS'(signed'({1'b0, 1'b1, {(COEF_FRAC-1){1'b0}}}));

  // Floor the rounded product back to integer units
  assign rnd = $signed(prod_q[PROD_BITS-1:COEF_FRAC]);

  // Saturating adders
  assign low_sum   = SUM_BITS'(low_dly_q) + SUM_BITS'(rnd);
  assign high_sum  = SUM_BITS'(x_q) - SUM_BITS'(low_q) - SUM_BITS'(rnd);
  assign band_sum  = SUM_BITS'(rnd) + SUM_BITS'(band_dly_q);
  assign notch_sum = SUM_BITS'(high_q) + SUM_BITS'(low_q);

  // Select the output tap
  always_comb begin
    unique case (mode_q)
      MODE_LOW:   sel = low_q;
      MODE_HIGH:  sel = high_q;
      MODE_BAND:  sel = band_q;
      MODE_NOTCH: sel = notch_q;
      default:    sel = low_q;
    endcase
  end

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_dly_q <= '0;
      low_dly_q  <= '0;
    end else if (busy_q && (uw.op == OP_BAND)) begin
      band_dly_q <= sat_state(band_sum);
      low_dly_q  <= low_q;
    end
  end

  // Datapath working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= s_axis_tdata;
    end
    if (busy_q) begin
      unique case (uw.op)
        OP_MUL:  prod_q <= prod_rnd;
        OP_LOW:  low_q  <= sat_state(low_sum);
        OP_HIGH: high_q <= sat_state(high_sum);
        OP_BAND: begin
          band_q  <= sat_state(band_sum);
          notch_q <= sat_state(notch_sum);
        end
        default: ;
      endcase
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (busy_q && (uw.op == OP_EMIT) && emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && (uw.op == OP_EMIT) && emit_ok) begin
      out_q <= sat_sample(sel);
    end
  end

  // Assertions
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (busy_q && (step_q == STEP_MUL_FB) && (pass_q == '0)))
    else $error("sequencer did not start at the first step");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pass_q <= pass_last_q))
    else $error("pass counter ran past the last pass");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= STEP_EMIT))
    else $error("step counter left the program");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(busy_q && (step_q == STEP_EMIT)))
    else $error("output raised outside the emit step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
    else $error("waiting result overwritten");

endmodule
